>>> rtl/jbc_pkg.sv
// Shared constants and types for the JSON bracket balance checker.
package jbc_pkg;

    // Default stack depth (entries)
    localparam int STACK_DEPTH = 64;

    // Characters the checker reacts to
    localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_NUL       = 8'h00;

    // Codes held on the open stack
    typedef enum logic [1:0] {
        CODE_BRACE   = 2'd0,
        CODE_BRACKET = 2'd1,
        CODE_QUOTE   = 2'd2
    } stack_code_t;

endpackage

>>> rtl/jbc_in_if.sv
// Input channel: one text byte per beat with a last marker.
interface jbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

>>> rtl/jbc_out_if.sv
// Output channel: one check verdict per beat.
interface jbc_out_if;
    logic valid;
    logic ready;
    logic json_ok;

    modport source (output valid, output json_ok, input ready);
    modport sink   (input valid, input json_ok, output ready);
endinterface

>>> rtl/json_bracket_balance_check.sv
// Top level of the JSON bracket balance checker.
//
// The block takes one byte of JSON text per beat on text and, on the beat
// marked last, delivers one verdict on result: json_ok is 1 when no bracket
// or quote mismatched, the open stack ends empty, no second top-level object
// or array was opened, and the text starts with '{' ending in '}' or starts
// with '[' ending in ']'. A zero byte ends checking for the rest of the
// message, a backslash makes the next byte be ignored, and overflowing the
// STACK_DEPTH-entry stack fails the message. A new byte is taken each cycle
// while input is not held off: the top of the stack sits in a register and
// the entry below it is read from the stack memory ahead of need, so a pop
// has its new top ready on the next beat. The verdict sits in an output
// register; input is held off only while that register is full and not
// being taken. The stack memory needs no clearing after reset.
module json_bracket_balance_check #(
    parameter int STACK_DEPTH = jbc_pkg::STACK_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    jbc_in_if.sink     text,
    jbc_out_if.source  result
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Stack memory and registers
    jbc_pkg::stack_code_t stack_mem [STACK_DEPTH];
    jbc_pkg::stack_code_t below_q;

    jbc_pkg::stack_code_t top_reg, top_next;
    logic                 pop_pend_reg, pop_pend_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 object_seen_reg, object_seen_next;
    logic                 array_seen_reg, array_seen_next;
    logic                 skip_reg, skip_next;
    logic                 failed_reg, failed_next;
    logic                 stopped_reg, stopped_next;
    logic                 at_start_reg, at_start_next;
    logic [7:0]           first_char_reg, first_char_next;
    logic [7:0]           last_char_reg, last_char_next;
    logic                 ovalid_reg, ovalid_next;
    logic                 ook_reg, ook_next;

    // Working signals
    logic                 accept;
    logic [7:0]           c;
    jbc_pkg::stack_code_t top_cur;
    logic                 stack_empty;
    logic                 stack_full;
    logic                 do_push;
    logic                 do_pop;
    jbc_pkg::stack_code_t push_code;
    logic [CW-1:0]        count_upd;
    logic                 object_upd, array_upd, skip_upd, failed_upd, stopped_upd;
    logic [7:0]           first_upd, last_upd;
    logic                 ok;
    logic [AW-1:0]        rd_addr;

    assign accept      = text.valid & text.ready;
    assign text.ready  = ~ovalid_reg | result.ready;
    assign c           = text.text_byte;
    assign result.valid   = ovalid_reg;
    assign result.json_ok = ook_reg;

    // Top of stack: fresh from memory right after a pop
    assign top_cur     = pop_pend_reg ? below_q : top_reg;
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CW'(STACK_DEPTH));
    assign rd_addr     = count_reg[AW-1:0] - AW'(2);

    // Decode one byte against the current stack
    always_comb
    begin
        do_push     = 1'b0;
        do_pop      = 1'b0;
        push_code   = jbc_pkg::CODE_BRACE;
        object_upd  = object_seen_reg;
        array_upd   = array_seen_reg;
        skip_upd    = skip_reg;
        failed_upd  = failed_reg;
        stopped_upd = stopped_reg;
        last_upd    = last_char_reg;
        first_upd   = at_start_reg ? c : first_char_reg;

        if (!stopped_reg && !failed_reg)
        begin
            if (skip_reg)
            begin
                skip_upd = 1'b0;
            end
            else if (c == jbc_pkg::CHAR_NUL)
            begin
                stopped_upd = 1'b1;
            end
            else
            begin
                last_upd = c;
                unique case (c)
                    jbc_pkg::CHAR_LBRACE:
                    begin
                        push_code = jbc_pkg::CODE_BRACE;
                        if (!object_seen_reg)
                        begin
                            object_upd = 1'b1;
                            do_push    = 1'b1;
                        end
                        else if (stack_empty)
                            failed_upd = 1'b1;
                        else
                            do_push = 1'b1;
                    end
                    jbc_pkg::CHAR_LBRACKET:
                    begin
                        push_code = jbc_pkg::CODE_BRACKET;
                        if (!array_seen_reg)
                        begin
                            array_upd = 1'b1;
                            do_push   = 1'b1;
                        end
                        else if (stack_empty)
                            failed_upd = 1'b1;
                        else
                            do_push = 1'b1;
                    end
                    jbc_pkg::CHAR_QUOTE:
                    begin
                        push_code = jbc_pkg::CODE_QUOTE;
                        if (!stack_empty && top_cur == jbc_pkg::CODE_QUOTE)
                            do_pop = 1'b1;
                        else
                            do_push = 1'b1;
                    end
                    jbc_pkg::CHAR_RBRACE:
                    begin
                        if (!stack_empty && top_cur == jbc_pkg::CODE_BRACE)
                            do_pop = 1'b1;
                        else
                            failed_upd = 1'b1;
                    end
                    jbc_pkg::CHAR_RBRACKET:
                    begin
                        if (!stack_empty && top_cur == jbc_pkg::CODE_BRACKET)
                            do_pop = 1'b1;
                        else
                            failed_upd = 1'b1;
                    end
                    jbc_pkg::CHAR_BACKSLASH:
                    begin
                        skip_upd = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                // Overflow turns the push into a failure
                if (do_push && stack_full)
                begin
                    do_push    = 1'b0;
                    failed_upd = 1'b1;
                end
            end
        end

        count_upd = count_reg;
        if (do_push)
            count_upd = count_reg + CW'(1);
        else if (do_pop)
            count_upd = count_reg - CW'(1);
    end

    // Verdict from the state after this byte
    always_comb
    begin
        ok = 1'b0;
        if (!failed_upd && count_upd == '0)
        begin
            if (first_upd == jbc_pkg::CHAR_LBRACE)
                ok = (last_upd == jbc_pkg::CHAR_RBRACE);
            else if (first_upd == jbc_pkg::CHAR_LBRACKET)
                ok = (last_upd == jbc_pkg::CHAR_RBRACKET);
        end
    end

    // Next state: advance on a beat, restart after the last byte
    always_comb
    begin
        top_next         = top_cur;
        pop_pend_next    = 1'b0;
        count_next       = count_reg;
        object_seen_next = object_seen_reg;
        array_seen_next  = array_seen_reg;
        skip_next        = skip_reg;
        failed_next      = failed_reg;
        stopped_next     = stopped_reg;
        at_start_next    = at_start_reg;
        first_char_next  = first_char_reg;
        last_char_next   = last_char_reg;
        ovalid_next      = ovalid_reg & ~result.ready;
        ook_next         = ook_reg;

        if (accept)
        begin
            if (text.is_last)
            begin
                count_next       = '0;
                object_seen_next = 1'b0;
                array_seen_next  = 1'b0;
                skip_next        = 1'b0;
                failed_next      = 1'b0;
                stopped_next     = 1'b0;
                at_start_next    = 1'b1;
                first_char_next  = '0;
                last_char_next   = '0;
                ovalid_next      = 1'b1;
                ook_next         = ok;
            end
            else
            begin
                if (do_push)
                    top_next = push_code;
                pop_pend_next    = do_pop;
                count_next       = count_upd;
                object_seen_next = object_upd;
                array_seen_next  = array_upd;
                skip_next        = skip_upd;
                failed_next      = failed_upd;
                stopped_next     = stopped_upd;
                at_start_next    = 1'b0;
                first_char_next  = first_upd;
                last_char_next   = last_upd;
            end
        end
    end

    // Stack memory: write pushed code at the fill level, read the entry below top
    always_ff @(posedge clk)
    begin
        if (accept && do_push)
            stack_mem[count_reg[AW-1:0]] <= push_code;
        below_q <= stack_mem[rd_addr];
    end

    // Hold top of stack and verdict payload
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        ook_reg <= ook_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_pend_reg    <= 1'b0;
            count_reg       <= '0;
            object_seen_reg <= 1'b0;
            array_seen_reg  <= 1'b0;
            skip_reg        <= 1'b0;
            failed_reg      <= 1'b0;
            stopped_reg     <= 1'b0;
            at_start_reg    <= 1'b1;
            first_char_reg  <= '0;
            last_char_reg   <= '0;
            ovalid_reg      <= 1'b0;
        end
        else
        begin
            pop_pend_reg    <= pop_pend_next;
            count_reg       <= count_next;
            object_seen_reg <= object_seen_next;
            array_seen_reg  <= array_seen_next;
            skip_reg        <= skip_next;
            failed_reg      <= failed_next;
            stopped_reg     <= stopped_next;
            at_start_reg    <= at_start_next;
            first_char_reg  <= first_char_next;
            last_char_reg   <= last_char_next;
            ovalid_reg      <= ovalid_next;
        end
    end

endmodule

>>> verif/json_bracket_balance_check_checker.sv
// Watches the byte and verdict channels, predicts every verdict and compares it.
module json_bracket_balance_check_checker #(
    parameter int STACK_DEPTH = jbc_pkg::STACK_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    jbc_in_if     text_mon,
    jbc_out_if    result_mon,
    output int    fail_count,
    output int    verdicts_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted message state
    jbc_pkg::stack_code_t open_marks [STACK_DEPTH];
    int          mark_depth;
    logic        brace_opened;
    logic        bracket_opened;
    logic        escape_armed;
    logic        broken;
    logic        halted;
    logic        at_head;
    logic [7:0]  head_char;
    logic [7:0]  tail_char;

    // Verdicts owed by the block, oldest first
    logic        expected_verdicts [$];

    task automatic clear_message();
        mark_depth     = 0;
        brace_opened   = 1'b0;
        bracket_opened = 1'b0;
        escape_armed   = 1'b0;
        broken         = 1'b0;
        halted         = 1'b0;
        at_head        = 1'b1;
        head_char      = jbc_pkg::CHAR_NUL;
        tail_char      = jbc_pkg::CHAR_NUL;
    endtask

    task automatic push_mark(input jbc_pkg::stack_code_t code);
        if (mark_depth >= STACK_DEPTH)
        begin
            broken = 1'b1;
        end
        else
        begin
            open_marks[mark_depth] = code;
            mark_depth = mark_depth + 1;
        end
    endtask

    function automatic logic top_mark_is(input jbc_pkg::stack_code_t code);
        return mark_depth > 0 && open_marks[mark_depth - 1] == code;
    endfunction

    // Apply one checked character to the open stack
    task automatic apply_char(input logic [7:0] c);
        case (c)
            jbc_pkg::CHAR_LBRACE:
            begin
                if (brace_opened && mark_depth == 0)
                    broken = 1'b1;
                else
                begin
                    brace_opened = 1'b1;
                    push_mark(jbc_pkg::CODE_BRACE);
                end
            end
            jbc_pkg::CHAR_LBRACKET:
            begin
                if (bracket_opened && mark_depth == 0)
                    broken = 1'b1;
                else
                begin
                    bracket_opened = 1'b1;
                    push_mark(jbc_pkg::CODE_BRACKET);
                end
            end
            jbc_pkg::CHAR_QUOTE:
            begin
                if (top_mark_is(jbc_pkg::CODE_QUOTE))
                    mark_depth = mark_depth - 1;
                else
                    push_mark(jbc_pkg::CODE_QUOTE);
            end
            jbc_pkg::CHAR_RBRACE:
            begin
                if (top_mark_is(jbc_pkg::CODE_BRACE))
                    mark_depth = mark_depth - 1;
                else
                    broken = 1'b1;
            end
            jbc_pkg::CHAR_RBRACKET:
            begin
                if (top_mark_is(jbc_pkg::CODE_BRACKET))
                    mark_depth = mark_depth - 1;
                else
                    broken = 1'b1;
            end
            jbc_pkg::CHAR_BACKSLASH:
            begin
                escape_armed = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    // Track one accepted byte; queue a verdict on the last byte
    task automatic track_byte(input logic [7:0] c, input logic last);
        logic ok;
        if (at_head)
        begin
            head_char = c;
            at_head   = 1'b0;
        end
        if (!halted && !broken)
        begin
            if (escape_armed)
                escape_armed = 1'b0;
            else if (c == jbc_pkg::CHAR_NUL)
                halted = 1'b1;
            else
            begin
                tail_char = c;
                apply_char(c);
            end
        end
        if (last)
        begin
            ok = 1'b0;
            if (!broken && mark_depth == 0)
            begin
                if (head_char == jbc_pkg::CHAR_LBRACE)
                    ok = (tail_char == jbc_pkg::CHAR_RBRACE);
                else if (head_char == jbc_pkg::CHAR_LBRACKET)
                    ok = (tail_char == jbc_pkg::CHAR_RBRACKET);
            end
            expected_verdicts.push_back(ok);
            clear_message();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_message();
            expected_verdicts.delete();
            fail_count       <= 0;
            verdicts_pending <= 0;
        end
        else
        begin
            // Compare a verdict beat with the oldest prediction
            if (result_mon.valid && result_mon.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("json_ok beat with no verdict pending: got %0d",
                           result_mon.json_ok);
                    fail_count <= fail_count + 1;
                end
                else if (result_mon.json_ok !== expected_verdicts[0])
                begin
                    $error("json_ok mismatch: expected %0d, got %0d",
                           expected_verdicts[0], result_mon.json_ok);
                    fail_count <= fail_count + 1;
                    void'(expected_verdicts.pop_front());
                end
                else
                begin
                    void'(expected_verdicts.pop_front());
                end
            end
            // Predict from a byte beat
            if (text_mon.valid && text_mon.ready)
                track_byte(text_mon.text_byte, text_mon.is_last);
            verdicts_pending <= expected_verdicts.size();
        end
    end

endmodule

>>> verif/json_bracket_balance_check_tb.sv
// Testbench top: drives JSON text messages into the checker block and gives the verdict.
module json_bracket_balance_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 16;

    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;

    typedef struct {
        bit is_obj;
        int left;
        bit started;
    } frame_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   verdicts_pending;
    int   cycle_count;
    int   items_sent;
    int   messages_sent;
    bit   calm;

    logic [7:0] msg_text [$];

    jbc_in_if  text_ch();
    jbc_out_if result_ch();

    json_bracket_balance_check u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    json_bracket_balance_check_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .text_mon         (text_ch),
        .result_mon       (result_ch),
        .fail_count       (fail_count),
        .verdicts_pending (verdicts_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bound the run
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("json_bracket_balance_check verification failed");
            $finish;
        end
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 6))
            0:       return jbc_pkg::CHAR_LBRACE;
            1:       return jbc_pkg::CHAR_RBRACE;
            2:       return jbc_pkg::CHAR_LBRACKET;
            3:       return jbc_pkg::CHAR_RBRACKET;
            4:       return jbc_pkg::CHAR_QUOTE;
            5:       return jbc_pkg::CHAR_BACKSLASH;
            default: return jbc_pkg::CHAR_NUL;
        endcase
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 1) == 0)
            return pick_special();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_text.push_back(s[i]);
    endtask

    // Quoted string with letters and escaped bytes of any value
    task automatic add_string();
        int n;
        n = $urandom_range(0, 4);
        msg_text.push_back(jbc_pkg::CHAR_QUOTE);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                msg_text.push_back(jbc_pkg::CHAR_BACKSLASH);
                msg_text.push_back(8'($urandom_range(0, 255)));
            end
            else
                msg_text.push_back(CHAR_LOWER_A + 8'($urandom_range(0, 25)));
        end
        msg_text.push_back(jbc_pkg::CHAR_QUOTE);
    endtask

    task automatic add_scalar();
        int n;
        n = $urandom_range(1, 4);
        case ($urandom_range(0, 2))
            0:
            begin
                add_string();
            end
            1:
            begin
                for (int i = 0; i < n; i++)
                    msg_text.push_back(CHAR_DIGIT_0 + 8'($urandom_range(0, 9)));
            end
            default:
            begin
                for (int i = 0; i < n; i++)
                    msg_text.push_back(CHAR_LOWER_A + 8'($urandom_range(0, 25)));
            end
        endcase
    endtask

    // Well-formed object or array, nested up to max_nest levels
    task automatic build_document(input int max_nest);
        frame_t frames [$];
        frame_t f;
        int     k;
        f.is_obj  = 1'($urandom_range(0, 1));
        f.left    = $urandom_range(0, 3);
        f.started = 1'b0;
        msg_text.push_back(f.is_obj ? jbc_pkg::CHAR_LBRACE : jbc_pkg::CHAR_LBRACKET);
        frames.push_back(f);
        while (frames.size() > 0)
        begin
            k = frames.size() - 1;
            if (frames[k].left == 0)
            begin
                msg_text.push_back(frames[k].is_obj ? jbc_pkg::CHAR_RBRACE
                                                    : jbc_pkg::CHAR_RBRACKET);
                void'(frames.pop_back());
            end
            else
            begin
                if (frames[k].started)
                    msg_text.push_back(CHAR_COMMA);
                frames[k].started = 1'b1;
                frames[k].left    = frames[k].left - 1;
                if (frames[k].is_obj)
                begin
                    add_string();
                    msg_text.push_back(CHAR_COLON);
                end
                if (frames.size() < max_nest && $urandom_range(0, 2) == 0)
                begin
                    f.is_obj  = 1'($urandom_range(0, 1));
                    f.left    = $urandom_range(0, 3);
                    f.started = 1'b0;
                    msg_text.push_back(f.is_obj ? jbc_pkg::CHAR_LBRACE
                                                : jbc_pkg::CHAR_LBRACKET);
                    frames.push_back(f);
                end
                else
                    add_scalar();
            end
        end
    endtask

    // Nest openers down to the given depth, then close them all
    task automatic build_deep(input int depth);
        logic [7:0] closers [$];
        for (int i = 0; i < depth; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                msg_text.push_back(jbc_pkg::CHAR_LBRACE);
                closers.push_front(jbc_pkg::CHAR_RBRACE);
            end
            else
            begin
                msg_text.push_back(jbc_pkg::CHAR_LBRACKET);
                closers.push_front(jbc_pkg::CHAR_RBRACKET);
            end
        end
        foreach (closers[i])
            msg_text.push_back(closers[i]);
    endtask

    // Break one spot of the message
    task automatic mutate_once();
        int pos;
        pos = $urandom_range(0, msg_text.size() - 1);
        case ($urandom_range(0, 4))
            0:
            begin
                msg_text[pos] = pick_char();
            end
            1:
            begin
                msg_text.insert(pos, pick_char());
            end
            2:
            begin
                if (msg_text.size() > 1)
                    msg_text.delete(pos);
            end
            3:
            begin
                msg_text.insert(pos, jbc_pkg::CHAR_NUL);
            end
            default:
            begin
                while (msg_text.size() > pos + 1)
                    void'(msg_text.pop_back());
            end
        endcase
    endtask

    // Send one byte beat; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_wait();
        repeat (gap)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.is_last   <= last;
        do
            @(posedge clk);
        while (!text_ch.ready);
        items_sent = items_sent + 1;
        @(negedge clk);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_text.size(); i++)
            send_byte(msg_text[i], i == msg_text.size() - 1);
        msg_text.delete();
        messages_sent = messages_sent + 1;
        calm = ($urandom_range(0, 7) == 0);
    endtask

    task automatic build_random_message();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            build_document($urandom_range(1, 3));
        else if (r < 80)
        begin
            build_document($urandom_range(1, 3));
            mutate_once();
        end
        else if (r < 84)
            build_deep($urandom_range(jbc_pkg::STACK_DEPTH - 4, jbc_pkg::STACK_DEPTH + 2));
        else if (r < 89)
        begin
            build_document(2);
            build_document(2);
        end
        else if (r < 92)
        begin
            build_document(3);
            msg_text.push_back(jbc_pkg::CHAR_BACKSLASH);
        end
        else
        begin
            r = $urandom_range(1, 12);
            for (int i = 0; i < r; i++)
                msg_text.push_back(pick_char());
        end
    endtask

    // Release the verdict channel, one stall draw per verdict
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            repeat (draw_wait())
            begin
                result_ch.ready <= 1'b0;
                @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n             = 1'b0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = jbc_pkg::CHAR_NUL;
        text_ch.is_last   = 1'b0;
        calm              = 1'b0;
        items_sent        = 0;
        messages_sent     = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Plain object and plain array
        push_text("{}");
        send_message();
        push_text("[]");
        send_message();
        // Escaped quote inside a string
        push_text("{\"\\\"\"}");
        send_message();
        // Mismatched closer, later bytes ignored
        push_text("{]}");
        send_message();
        // Zero as first byte
        msg_text.push_back(jbc_pkg::CHAR_NUL);
        push_text("{");
        send_message();
        // Zero ends checking mid-message
        push_text("{");
        msg_text.push_back(jbc_pkg::CHAR_NUL);
        push_text("}");
        send_message();
        // Second top-level object
        push_text("{}{}");
        send_message();
        // Escape pending at the last byte
        push_text("[]\\");
        send_message();
        // Escaped zero is skipped
        push_text("[\\");
        msg_text.push_back(jbc_pkg::CHAR_NUL);
        push_text("]");
        send_message();

        // Stack exactly full, then one past full
        build_deep(jbc_pkg::STACK_DEPTH);
        send_message();
        build_deep(jbc_pkg::STACK_DEPTH + 1);
        send_message();

        while (items_sent < ITEM_TARGET)
        begin
            build_random_message();
            send_message();
        end
        text_ch.valid <= 1'b0;

        // Drain outstanding verdicts
        while (verdicts_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("json_bracket_balance_check verification clean");
        else
            $display("json_bracket_balance_check verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/jbc_pkg.sv
rtl/jbc_in_if.sv
rtl/jbc_out_if.sv
rtl/json_bracket_balance_check.sv
verif/json_bracket_balance_check_checker.sv
verif/json_bracket_balance_check_tb.sv
